### src/tnrm_pkg.sv
// Shared types and constants for the tower neighbour reject mask block.
// No dependencies; compiled first.
package tnrm_pkg;

   localparam int NUM_SECTORS_DEF  = 8;
   localparam int MAX_Z_TOWERS_DEF = 96;
   localparam int MAX_Y_TOWERS_DEF = 48;

   localparam logic       REQ_QUERY     = 1'b1;
   localparam logic       REQ_LOAD      = 1'b0;
   localparam logic [1:0] ARM_MAX       = 2'd1;
   localparam logic [2:0] SECTOR_MAX    = 3'd3;
   localparam logic [2:0] SMALL_HW_LAST = 3'd5;
   localparam logic [2:0] WIN_LAST_COL  = 3'd4;

   localparam logic [1:0] CSR_SMALL_Z = 2'd0;
   localparam logic [1:0] CSR_SMALL_Y = 2'd1;
   localparam logic [1:0] CSR_LARGE_Z = 2'd2;
   localparam logic [1:0] CSR_LARGE_Y = 2'd3;

   localparam logic [2:0] SW_TO_HW [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7, 3'd4, 3'd5};

   localparam logic [6:0] SMALL_Z_RESET = 7'd72;
   localparam logic [5:0] SMALL_Y_RESET = 6'd36;
   localparam logic [6:0] LARGE_Z_RESET = 7'd96;
   localparam logic [5:0] LARGE_Y_RESET = 6'd48;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_QUERY,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      logic [6:0] small_z;
      logic [5:0] small_y;
      logic [6:0] large_z;
      logic [5:0] large_y;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic        is_large;
      logic        reject_value;
      logic [6:0]  tz;
      logic [5:0]  ty;
      logic [7:0]  zlim;
      logic [4:0]  yok;
      logic [31:0] dead_word;
   } item_type;

   typedef struct packed {
      logic        first;
      logic        last;
      kind_type    kind;
      logic        is_large;
      logic        zok;
      logic [2:0]  col;
      logic [5:0]  ty;
      logic [4:0]  yok;
      logic [31:0] dead_word;
   } beat_type;

endpackage

### src/tnrm_req_if.sv
// Request channel: valid/ready handshake with the load/query payload.
// No dependencies.
interface tnrm_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  arm_index;
   logic [2:0]  sector_index;
   logic [5:0]  tower_y;
   logic [6:0]  tower_z;
   logic        reject_value;
   logic [31:0] existing_dead_word;

   modport source (output valid, req_type, arm_index, sector_index, tower_y, tower_z,
                   reject_value, existing_dead_word, input ready);
   modport sink (input valid, req_type, arm_index, sector_index, tower_y, tower_z,
                 reject_value, existing_dead_word, output ready);
endinterface

### src/tnrm_rsp_if.sv
// Response channel: valid/ready handshake with the mask result payload.
// No dependencies.
interface tnrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] neighbour_mask;
   logic [31:0] result_word;
   logic        goes_to_dead_map;
   logic        index_error;

   modport source (output valid, neighbour_mask, result_word, goes_to_dead_map, index_error,
                   input ready);
   modport sink (input valid, neighbour_mask, result_word, goes_to_dead_map, index_error,
                 output ready);
endinterface

### src/tnrm_store.sv
// Reject bit store: one row of y bits per sector/z, bit write, registered read.
// Runs a clearing pass after reset. Uses tnrm_pkg defaults.
module tnrm_store #(
   parameter  int NUM_SECTORS  = tnrm_pkg::NUM_SECTORS_DEF,
   parameter  int MAX_Z_TOWERS = tnrm_pkg::MAX_Z_TOWERS_DEF,
   parameter  int MAX_Y_TOWERS = tnrm_pkg::MAX_Y_TOWERS_DEF,
   localparam int DEPTH        = NUM_SECTORS * MAX_Z_TOWERS,
   localparam int AW           = $clog2(DEPTH),
   localparam int YW           = $clog2(MAX_Y_TOWERS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [YW-1:0]           wr_bit,
   input  logic                    wr_value,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic [MAX_Y_TOWERS-1:0] rd_data,
   output logic                    clr_busy
);

   logic [MAX_Y_TOWERS-1:0] mem_ff [DEPTH];
   logic [MAX_Y_TOWERS-1:0] rd_data_ff;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic                    clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr][wr_bit] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

### src/tnrm_decode.sv
// Input stage: takes a request, maps arm/sector to hardware sector, checks range,
// clamps grid sizes and registers the decoded item. Uses tnrm_pkg, tnrm_req_if.
module tnrm_decode #(
   parameter  int NUM_SECTORS  = tnrm_pkg::NUM_SECTORS_DEF,
   parameter  int MAX_Z_TOWERS = tnrm_pkg::MAX_Z_TOWERS_DEF,
   parameter  int MAX_Y_TOWERS = tnrm_pkg::MAX_Y_TOWERS_DEF,
   localparam int AW           = $clog2(NUM_SECTORS * MAX_Z_TOWERS)
) (
   input  logic               clock,
   input  logic               reset,
   tnrm_req_if.sink           req_bus,
   input  tnrm_pkg::cfg_type  cfg,
   input  logic               adv,
   input  logic               take,
   input  logic               clr_busy,
   output logic               item_valid,
   output tnrm_pkg::item_type item,
   output logic [AW-1:0]      base
);

   logic               valid_ff, valid_in;
   tnrm_pkg::item_type item_ff, item_in;
   logic [AW-1:0]      base_ff, base_in;
   tnrm_pkg::item_type dec;
   logic [2:0]         hw;
   logic [6:0]         zreg;
   logic [5:0]         yreg;
   logic [6:0]         ylim;
   logic [6:0]         yp;
   logic               bad;
   logic               load_en;

   assign load_en       = adv && (!valid_ff || take);
   assign req_bus.ready = load_en && !clr_busy;

   always_comb begin
      hw           = tnrm_pkg::SW_TO_HW[{req_bus.arm_index[0], req_bus.sector_index[1:0]}];
      dec.is_large = hw > tnrm_pkg::SMALL_HW_LAST;
      zreg         = dec.is_large ? cfg.large_z : cfg.small_z;
      yreg         = dec.is_large ? cfg.large_y : cfg.small_y;
      dec.zlim  = ({1'b0, zreg} > 8'(MAX_Z_TOWERS)) ? 8'(MAX_Z_TOWERS) : {1'b0, zreg};
      ylim      = ({1'b0, yreg} > 7'(MAX_Y_TOWERS)) ? 7'(MAX_Y_TOWERS) : {1'b0, yreg};
      bad = (req_bus.arm_index > tnrm_pkg::ARM_MAX)
         || (req_bus.sector_index > tnrm_pkg::SECTOR_MAX)
         || ({1'b0, req_bus.tower_y} >= 7'(MAX_Y_TOWERS))
         || ({1'b0, req_bus.tower_z} >= 8'(MAX_Z_TOWERS))
         || ({1'b0, hw} >= 4'(NUM_SECTORS));
      if (bad) begin
         dec.kind = tnrm_pkg::KIND_ERROR;
      end else if (req_bus.req_type == tnrm_pkg::REQ_QUERY) begin
         dec.kind = tnrm_pkg::KIND_QUERY;
      end else begin
         dec.kind = tnrm_pkg::KIND_LOAD;
      end
      dec.reject_value = req_bus.reject_value;
      dec.tz           = req_bus.tower_z;
      dec.ty           = req_bus.tower_y;
      dec.dead_word    = req_bus.existing_dead_word;
      yp               = '0;
      for (int d = 0; d < 5; d++) begin
         yp         = {1'b0, req_bus.tower_y} + 7'(d);
         dec.yok[d] = (yp >= 7'd2) && (yp < ylim + 7'd2);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      base_in  = base_ff;
      if (load_en) begin
         valid_in = req_bus.valid && req_bus.ready;
         item_in  = dec;
         base_in  = AW'(int'(hw) * MAX_Z_TOWERS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
      base_ff <= base_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign base       = base_ff;

endmodule

### src/tnrm_issue.sv
// Store access sequencer: one write for a load, five column reads for a query.
// Uses tnrm_pkg.
module tnrm_issue #(
   parameter  int NUM_SECTORS  = tnrm_pkg::NUM_SECTORS_DEF,
   parameter  int MAX_Z_TOWERS = tnrm_pkg::MAX_Z_TOWERS_DEF,
   parameter  int MAX_Y_TOWERS = tnrm_pkg::MAX_Y_TOWERS_DEF,
   localparam int AW           = $clog2(NUM_SECTORS * MAX_Z_TOWERS),
   localparam int YW           = $clog2(MAX_Y_TOWERS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               item_valid,
   input  tnrm_pkg::item_type item,
   input  logic [AW-1:0]      base,
   output logic               take,
   output logic               beat_valid,
   output tnrm_pkg::beat_type beat,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [YW-1:0]      wr_bit,
   output logic               wr_value,
   output logic [AW-1:0]      rd_addr
);

   logic               valid_ff, valid_in;
   tnrm_pkg::item_type iss_ff, iss_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [2:0]         col_ff, col_in;
   logic               last;
   logic [7:0]         zp;
   logic [7:0]         zn;
   logic [AW-1:0]      zoff;
   logic [AW-1:0]      addr;

   always_comb begin
      last = (iss_ff.kind != tnrm_pkg::KIND_QUERY) || (col_ff == tnrm_pkg::WIN_LAST_COL);
      take = adv && (!valid_ff || last);
      zp   = {1'b0, iss_ff.tz} + 8'(col_ff);
      zn   = zp - 8'd2;
      zoff = (iss_ff.kind == tnrm_pkg::KIND_LOAD) ? AW'(iss_ff.tz) : AW'(zn);
      addr = base_ff + zoff;

      beat.first     = (col_ff == 3'd0);
      beat.last      = last;
      beat.kind      = iss_ff.kind;
      beat.is_large  = iss_ff.is_large;
      beat.zok       = (zp >= 8'd2) && (zp < iss_ff.zlim + 8'd2);
      beat.col       = col_ff;
      beat.ty        = iss_ff.ty;
      beat.yok       = iss_ff.yok;
      beat.dead_word = iss_ff.dead_word;
      beat_valid     = valid_ff;

      wr_en    = adv && valid_ff && (iss_ff.kind == tnrm_pkg::KIND_LOAD);
      wr_addr  = addr;
      wr_bit   = YW'(iss_ff.ty);
      wr_value = iss_ff.reject_value;
      rd_addr  = addr;
   end

   always_comb begin
      valid_in = valid_ff;
      iss_in   = iss_ff;
      base_in  = base_ff;
      col_in   = col_ff;
      if (take) begin
         valid_in = item_valid;
         iss_in   = item;
         base_in  = base;
         col_in   = 3'd0;
      end else if (adv && valid_ff) begin
         col_in = col_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         col_ff   <= col_in;
      end
      iss_ff  <= iss_in;
      base_ff <= base_in;
   end

endmodule

### src/tnrm_window.sv
// Window assembly: picks five y bits per column read, builds the 21-bit mask,
// merges the dead map word and holds the response. Uses tnrm_pkg, tnrm_rsp_if.
module tnrm_window #(
   parameter  int MAX_Y_TOWERS = tnrm_pkg::MAX_Y_TOWERS_DEF,
   localparam int YW           = $clog2(MAX_Y_TOWERS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    beat_valid,
   input  tnrm_pkg::beat_type      beat,
   input  logic [MAX_Y_TOWERS-1:0] rd_data,
   output logic                    adv,
   tnrm_rsp_if.source              rsp_bus
);

   logic               rb_valid_ff, rb_valid_in;
   tnrm_pkg::beat_type rb_ff, rb_in;
   logic [20:0]        acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [20:0]        mask_ff, mask_in;
   logic [31:0]        word_ff, word_in;
   logic               dead_ff, dead_in;
   logic               err_ff, err_in;
   logic [6:0]         yi;
   logic [4:0]         ybits;
   logic [20:0]        merged;
   logic               is_query;

   // Column col is z offset col-2; rows y-2 and y+2 only cover z-1..z+1.
   function automatic logic [20:0] place_col(input logic [2:0] col, input logic [4:0] bits);
      logic [20:0] m;
      m = '0;
      for (int r = 0; r < 3; r++) begin
         m[5'(r * 5 + 3) + 5'(col)] = bits[r + 1];
      end
      if (col != 3'd0 && col != tnrm_pkg::WIN_LAST_COL) begin
         m[5'(col) - 5'd1]  = bits[0];
         m[5'(col) + 5'd17] = bits[4];
      end
      return m;
   endfunction

   assign adv = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      yi = '0;
      for (int d = 0; d < 5; d++) begin
         yi       = {1'b0, rb_ff.ty} + 7'(d) - 7'd2;
         ybits[d] = rb_ff.zok && rb_ff.yok[d] && rd_data[YW'(yi)];
      end
      merged   = (rb_ff.first ? 21'd0 : acc_ff) | place_col(rb_ff.col, ybits);
      is_query = (rb_ff.kind == tnrm_pkg::KIND_QUERY);
   end

   always_comb begin
      rb_valid_in  = rb_valid_ff;
      rb_in        = rb_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      mask_in      = mask_ff;
      word_in      = word_ff;
      dead_in      = dead_ff;
      err_in       = err_ff;
      if (adv) begin
         rb_valid_in  = beat_valid;
         rb_in        = beat;
         rsp_valid_in = rb_valid_ff && rb_ff.last;
         if (rb_valid_ff) begin
            acc_in = merged;
            if (rb_ff.last) begin
               mask_in = is_query ? merged : 21'd0;
               dead_in = is_query && rb_ff.is_large;
               word_in = dead_in ? (rb_ff.dead_word | 32'(mask_in)) : 32'(mask_in);
               err_in  = (rb_ff.kind == tnrm_pkg::KIND_ERROR);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rb_valid_ff  <= rb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rb_ff   <= rb_in;
      acc_ff  <= acc_in;
      mask_ff <= mask_in;
      word_ff <= word_in;
      dead_ff <= dead_in;
      err_ff  <= err_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.neighbour_mask   = mask_ff;
   assign rsp_bus.result_word      = word_ff;
   assign rsp_bus.goes_to_dead_map = dead_ff;
   assign rsp_bus.index_error      = err_ff;

endmodule

### src/tower_neighbour_reject_mask.sv
// Top level of the tower neighbour reject mask block: size registers and pipeline.
// Uses tnrm_pkg, tnrm_req_if, tnrm_rsp_if, tnrm_decode, tnrm_issue, tnrm_store,
// tnrm_window.
//
// Usage:
//   req_bus carries load requests (write one tower's reject bit) and query requests
//   (21-bit mask of rejected towers in the 5x5 window, corners removed). rsp_bus
//   returns exactly one response per request, in order. csr_* writes the four
//   grid size registers; write them only while no request is in flight.
//   Path: an accepted request is registered in decode, then in issue, then in the
//   window read-back register and last in the response register.
//   Throughput: loads and out-of-range requests 1 per cycle while rsp ready is high;
//   a query holds the store read port for five z columns of the window, one per cycle.
//   Reset: sizes return to 72/36/96/48 and the store is cleared, one row per
//   cycle, over all NUM_SECTORS*MAX_Z_TOWERS rows (768 by default) with req ready low.
//   Stall: while a response waits on rsp ready the whole pipeline holds and req
//   ready is low; req ready follows rsp ready combinationally.
module tower_neighbour_reject_mask #(
   parameter  int NUM_SECTORS  = tnrm_pkg::NUM_SECTORS_DEF,
   parameter  int MAX_Z_TOWERS = tnrm_pkg::MAX_Z_TOWERS_DEF,
   parameter  int MAX_Y_TOWERS = tnrm_pkg::MAX_Y_TOWERS_DEF,
   localparam int AW           = $clog2(NUM_SECTORS * MAX_Z_TOWERS),
   localparam int YW           = $clog2(MAX_Y_TOWERS)
) (
   input  logic       clock,
   input  logic       reset,
   tnrm_req_if.sink   req_bus,
   tnrm_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wr_data
);

   tnrm_pkg::cfg_type  cfg_ff, cfg_in;
   logic               adv;
   logic               take;
   logic               clr_busy;
   logic               item_valid;
   tnrm_pkg::item_type item;
   logic [AW-1:0]      base;
   logic               beat_valid;
   tnrm_pkg::beat_type beat;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [YW-1:0]      wr_bit;
   logic               wr_value;
   logic [AW-1:0]      rd_addr;
   logic [MAX_Y_TOWERS-1:0] rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tnrm_pkg::CSR_SMALL_Z: cfg_in.small_z = csr_wr_data;
            tnrm_pkg::CSR_SMALL_Y: cfg_in.small_y = csr_wr_data[5:0];
            tnrm_pkg::CSR_LARGE_Z: cfg_in.large_z = csr_wr_data;
            tnrm_pkg::CSR_LARGE_Y: cfg_in.large_y = csr_wr_data[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{small_z: tnrm_pkg::SMALL_Z_RESET, small_y: tnrm_pkg::SMALL_Y_RESET,
                     large_z: tnrm_pkg::LARGE_Z_RESET, large_y: tnrm_pkg::LARGE_Y_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tnrm_decode #(
      .NUM_SECTORS (NUM_SECTORS),
      .MAX_Z_TOWERS(MAX_Z_TOWERS),
      .MAX_Y_TOWERS(MAX_Y_TOWERS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .adv       (adv),
      .take      (take),
      .clr_busy  (clr_busy),
      .item_valid(item_valid),
      .item      (item),
      .base      (base)
   );

   tnrm_issue #(
      .NUM_SECTORS (NUM_SECTORS),
      .MAX_Z_TOWERS(MAX_Z_TOWERS),
      .MAX_Y_TOWERS(MAX_Y_TOWERS)
   ) u_issue (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .item_valid(item_valid),
      .item      (item),
      .base      (base),
      .take      (take),
      .beat_valid(beat_valid),
      .beat      (beat),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_bit    (wr_bit),
      .wr_value  (wr_value),
      .rd_addr   (rd_addr)
   );

   tnrm_store #(
      .NUM_SECTORS (NUM_SECTORS),
      .MAX_Z_TOWERS(MAX_Z_TOWERS),
      .MAX_Y_TOWERS(MAX_Y_TOWERS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_bit  (wr_bit),
      .wr_value(wr_value),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .clr_busy(clr_busy)
   );

   tnrm_window #(
      .MAX_Y_TOWERS(MAX_Y_TOWERS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .beat_valid(beat_valid),
      .beat      (beat),
      .rd_data   (rd_data),
      .adv       (adv),
      .rsp_bus   (rsp_bus)
   );

`ifndef SYNTHESIS
   a_no_request_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_bus.ready)
      else $error("request taken during store clear");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !clr_busy)
      else $error("load write during store clear");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> (!wr_en && !take))
      else $error("pipeline moved while response stalled");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.index_error) |->
         (rsp_bus.neighbour_mask == 21'd0 && rsp_bus.result_word == 32'd0
          && !rsp_bus.goes_to_dead_map))
      else $error("out-of-range response carries data");
`endif

endmodule

### bench/tb_tower_neighbour_reject_mask.sv
`timescale 1ns / 100ps
// Testbench for tower_neighbour_reject_mask: directed and random load/query requests,
// an in-bench reject map that predicts every response, and several grid size settings.
// Depends on tnrm_pkg, tnrm_req_if, tnrm_rsp_if and the block itself.
module tb_tower_neighbour_reject_mask;

   localparam int GRID_Z = tnrm_pkg::MAX_Z_TOWERS_DEF;
   localparam int GRID_Y = tnrm_pkg::MAX_Y_TOWERS_DEF;
   localparam int HW_SECTORS = tnrm_pkg::NUM_SECTORS_DEF;
   localparam int RANDOM_ITEMS = 1700;
   localparam int PHASES = 7;
   localparam int SMALL_LAST = int'(tnrm_pkg::SMALL_HW_LAST);

   typedef struct packed {
      logic        kind;
      logic [1:0]  arm;
      logic [2:0]  sector;
      logic [5:0]  y;
      logic [6:0]  z;
      logic        reject_value;
      logic [31:0] dead_word;
   } tower_request_type;

   typedef struct packed {
      logic [20:0] mask;
      logic [31:0] word;
      logic        dead_map;
      logic        index_error;
   } window_result_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [6:0] csr_wr_data;

   tnrm_req_if req_bus ();
   tnrm_rsp_if rsp_bus ();

   tower_neighbour_reject_mask uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   bit [GRID_Y-1:0] reject_rows [HW_SECTORS*GRID_Z];
   bit [6:0] small_z_size = tnrm_pkg::SMALL_Z_RESET;
   bit [5:0] small_y_size = tnrm_pkg::SMALL_Y_RESET;
   bit [6:0] large_z_size = tnrm_pkg::LARGE_Z_RESET;
   bit [5:0] large_y_size = tnrm_pkg::LARGE_Y_RESET;

   tower_request_type pending_requests[$];
   window_result_type expected_windows[$];
   tower_request_type in_flight;
   int queued_total = 0;
   int sent_count = 0;
   int checked_count = 0;
   int failures = 0;
   int gap_left = 0;
   int stall_left = 0;

   // Mostly short gaps, a few long ones, and calm stretches with none.
   function automatic int pick_gap(int count);
      int r;
      r = $urandom_range(0, 99);
      if ((count % 256) < 48) return 0;
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_to(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic window_result_type evaluate_request(tower_request_type rq);
      window_result_type res;
      bit [2:0] hw;
      int zs, ys, row, col, bitpos, nz, ny, base;
      res = '0;
      if (rq.arm > tnrm_pkg::ARM_MAX || rq.sector > tnrm_pkg::SECTOR_MAX
          || int'(rq.y) >= GRID_Y || int'(rq.z) >= GRID_Z) begin
         res.index_error = 1'b1;
         return res;
      end
      hw = tnrm_pkg::SW_TO_HW[{rq.arm[0], rq.sector[1:0]}];
      base = int'(hw) * GRID_Z;
      if (rq.kind == tnrm_pkg::REQ_LOAD) begin
         reject_rows[base + int'(rq.z)][rq.y] = rq.reject_value;
         return res;
      end
      zs = (hw > tnrm_pkg::SMALL_HW_LAST) ? int'(large_z_size) : int'(small_z_size);
      ys = (hw > tnrm_pkg::SMALL_HW_LAST) ? int'(large_y_size) : int'(small_y_size);
      if (zs > GRID_Z) zs = GRID_Z;
      if (ys > GRID_Y) ys = GRID_Y;
      bitpos = 0;
      for (row = -2; row <= 2; row++) begin
         for (col = -2; col <= 2; col++) begin
            if ((row == -2 || row == 2) && (col == -2 || col == 2)) continue;
            nz = int'(rq.z) + col;
            ny = int'(rq.y) + row;
            if (nz >= 0 && ny >= 0 && nz < zs && ny < ys && reject_rows[base + nz][ny])
               res.mask[bitpos] = 1'b1;
            bitpos++;
         end
      end
      if (hw > tnrm_pkg::SMALL_HW_LAST) begin
         res.word = rq.dead_word | {11'd0, res.mask};
         res.dead_map = 1'b1;
      end else begin
         res.word = {11'd0, res.mask};
      end
      return res;
   endfunction

   task automatic queue_request(input logic kind, input int arm, input int sector, input int y,
                                input int z, input logic rval, input logic [31:0] dead);
      tower_request_type rq;
      rq.kind = kind;
      rq.arm = 2'(arm);
      rq.sector = 3'(sector);
      rq.y = 6'(y);
      rq.z = 7'(z);
      rq.reject_value = rval;
      rq.dead_word = dead;
      pending_requests.push_back(rq);
      queued_total++;
   endtask

   // Loads around one tower, then queries near it; a broken cluster queries elsewhere.
   task automatic queue_cluster(input bit broken, output int count);
      int arm, sector, hw, zs, ys, cy, cz, n, i, qy, qz;
      arm = $urandom_range(0, 1);
      sector = $urandom_range(0, 3);
      hw = int'(tnrm_pkg::SW_TO_HW[arm*4 + sector]);
      zs = (hw > SMALL_LAST) ? int'(large_z_size) : int'(small_z_size);
      ys = (hw > SMALL_LAST) ? int'(large_y_size) : int'(small_y_size);
      case ($urandom_range(0, 3))
         0: begin
            cy = $urandom_range(0, GRID_Y - 1);
            cz = $urandom_range(0, GRID_Z - 1);
         end
         1: begin
            cy = $urandom_range(0, 2);
            cz = $urandom_range(0, 2);
         end
         2: begin
            cy = GRID_Y - 1 - $urandom_range(0, 2);
            cz = GRID_Z - 1 - $urandom_range(0, 2);
         end
         default: begin
            cy = clamp_to(ys + $urandom_range(0, 4) - 2, GRID_Y - 1);
            cz = clamp_to(zs + $urandom_range(0, 4) - 2, GRID_Z - 1);
         end
      endcase
      count = 0;
      n = $urandom_range(2, 8);
      for (i = 0; i < n; i++) begin
         queue_request(tnrm_pkg::REQ_LOAD, arm, sector,
                       clamp_to(cy + $urandom_range(0, 4) - 2, GRID_Y - 1),
                       clamp_to(cz + $urandom_range(0, 4) - 2, GRID_Z - 1),
                       $urandom_range(0, 3) != 0, $urandom);
         count++;
      end
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         qy = clamp_to(cy + $urandom_range(0, 2) - 1, GRID_Y - 1);
         qz = clamp_to(cz + $urandom_range(0, 2) - 1, GRID_Z - 1);
         if (broken) begin
            case ($urandom_range(0, 3))
               0: sector = $urandom_range(0, 7);
               1: arm = $urandom_range(0, 3);
               2: qy = qy + GRID_Y - $urandom_range(0, 2) * 8;
               default: qz = qz + GRID_Z - $urandom_range(0, 3) * 16;
            endcase
            qy = clamp_to(qy, 63);
            qz = clamp_to(qz, 127);
         end
         queue_request(tnrm_pkg::REQ_QUERY, arm, sector, qy, qz,
                       1'($urandom_range(0, 1)), $urandom);
         count++;
      end
   endtask

   task automatic write_size(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= 7'(value);
      case (idx)
         tnrm_pkg::CSR_SMALL_Z: small_z_size = 7'(value);
         tnrm_pkg::CSR_SMALL_Y: small_y_size = 6'(value);
         tnrm_pkg::CSR_LARGE_Z: large_z_size = 7'(value);
         tnrm_pkg::CSR_LARGE_Y: large_y_size = 6'(value);
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (checked_count != queued_total) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.req_type <= tnrm_pkg::REQ_LOAD;
         req_bus.arm_index <= '0;
         req_bus.sector_index <= '0;
         req_bus.tower_y <= '0;
         req_bus.tower_z <= '0;
         req_bus.reject_value <= 1'b0;
         req_bus.existing_dead_word <= '0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_windows.push_back(evaluate_request(in_flight));
            sent_count++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the request until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            in_flight = pending_requests.pop_front();
            req_bus.req_type <= in_flight.kind;
            req_bus.arm_index <= in_flight.arm;
            req_bus.sector_index <= in_flight.sector;
            req_bus.tower_y <= in_flight.y;
            req_bus.tower_z <= in_flight.z;
            req_bus.reject_value <= in_flight.reject_value;
            req_bus.existing_dead_word <= in_flight.dead_word;
            req_bus.valid <= 1'b1;
            gap_left = pick_gap(sent_count);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_windows.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual mask %0h word %0h",
                        $time, rsp_bus.neighbour_mask, rsp_bus.result_word);
               failures++;
            end else begin
               want = expected_windows.pop_front();
               check_field("neighbour_mask", 32'(want.mask), 32'(rsp_bus.neighbour_mask));
               check_field("result_word", want.word, rsp_bus.result_word);
               check_field("goes_to_dead_map", 32'(want.dead_map),
                           32'(rsp_bus.goes_to_dead_map));
               check_field("index_error", 32'(want.index_error), 32'(rsp_bus.index_error));
               checked_count++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(checked_count + 100);
         end
      end
   end

   initial begin
      int phase, pushed, target, n;
      int sizes [4];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = tnrm_pkg::CSR_SMALL_Z;
      csr_wr_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      target = RANDOM_ITEMS / PHASES;
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: sizes = '{72, 36, 96, 48};
            1: sizes = '{96, 48, 96, 48};
            2: sizes = '{1, 1, 1, 1};
            3: sizes = '{127, 63, 0, 0};
            5: sizes = '{0, 0, 127, 63};
            6: sizes = '{5, 3, 4, 2};
            default: sizes = '{$urandom_range(1, 96), $urandom_range(1, 48),
                               $urandom_range(1, 96), $urandom_range(1, 48)};
         endcase
         write_size(tnrm_pkg::CSR_SMALL_Z, sizes[0]);
         write_size(tnrm_pkg::CSR_SMALL_Y, sizes[1]);
         write_size(tnrm_pkg::CSR_LARGE_Z, sizes[2]);
         write_size(tnrm_pkg::CSR_LARGE_Y, sizes[3]);

         if (phase == 0) begin
            // grid corner at origin, negative neighbours skipped, window corner dropped
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 0, 0, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 0, 1, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 1, 0, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 2, 2, 1'b1, 32'hFFFF_FFFF);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 0, 0, 0, 1'b0, 32'hFFFF_FFFF);
            // far corner of a large sector, dead map merge
            queue_request(tnrm_pkg::REQ_LOAD, 1, 0, 47, 95, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 1, 0, 46, 94, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 1, 0, 45, 93, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 1, 0, 47, 95, 1'b1, 32'hA5A5_0000);
            queue_request(tnrm_pkg::REQ_QUERY, 1, 1, 0, 0, 1'b0, 32'hFFFF_FFFF);
            // clearing a bit
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 0, 1, 1'b0, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 0, 1, 1, 1'b0, 32'h0);
            // tower beyond the small sector size but inside the grid
            queue_request(tnrm_pkg::REQ_LOAD, 0, 1, 40, 80, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 1, 40, 80, 1'b0, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 1, 3, 35, 71, 1'b1, 32'h1234_5678);
            // out-of-range indices, then an in-range query
            queue_request(tnrm_pkg::REQ_LOAD, 2, 0, 0, 0, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 3, 3, 5, 5, 1'b1, 32'hFFFF_FFFF);
            queue_request(tnrm_pkg::REQ_LOAD, 0, 4, 0, 0, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 1, 7, 10, 10, 1'b0, 32'hFFFF_FFFF);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 0, 48, 0, 1'b0, 32'h0);
            queue_request(tnrm_pkg::REQ_LOAD, 0, 0, 63, 127, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 2, 0, 96, 1'b1, 32'h0);
            queue_request(tnrm_pkg::REQ_QUERY, 0, 0, 0, 1, 1'b0, 32'h0);
         end

         pushed = 0;
         while (pushed < target) begin
            case ($urandom_range(0, 99)) inside
               [0:69]: queue_cluster(1'b0, n);
               [70:84]: begin
                  queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 3),
                                $urandom_range(0, 7), $urandom_range(0, 63),
                                $urandom_range(0, 127), 1'($urandom_range(0, 1)), $urandom);
                  n = 1;
               end
               default: queue_cluster(1'b1, n);
            endcase
            pushed += n;
         end
      end

      drain();
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
